>>> design/medt_pkg.sv
// Shared types and constants for the mesh edge dedup table.
`default_nettype none
package medt_pkg;

   localparam int VERT_W       = 12;
   localparam int EDGE_IDX_W   = 13;
   localparam int MIDPOINT_W   = 14;
   localparam int COUNT_W      = 14;
   localparam int MASK_W       = 2;
   localparam int BASE_W       = 12;
   localparam int BBITS_W      = 4;
   localparam int BUCKET_W     = 16;
   localparam int BUCKET_MIN   = 4;

   localparam int EDGE_CAPACITY_DEF   = 8192;
   localparam int BUCKET_BITS_MAX_DEF = 12;

   localparam logic [31:0] HASH_MUL_LOW  = 32'd73856093;
   localparam logic [31:0] HASH_MUL_HIGH = 32'd19349663;

   localparam logic [MASK_W-1:0] FACE_FRONT = 2'd1;
   localparam logic [MASK_W-1:0] FACE_BACK  = 2'd2;

   localparam logic CSR_BASE_VERTEX = 1'b0;
   localparam logic CSR_BUCKET_BITS = 1'b1;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_READ   = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_NODE,
      ST_MISS,
      ST_READ,
      ST_OUT
   } medt_state_type;

   typedef struct packed {
      req_kind_type            kind;
      logic [VERT_W-1:0]       lo;
      logic [VERT_W-1:0]       hi;
      logic                    front;
      logic [EDGE_IDX_W-1:0]   sel;
      logic [BUCKET_W-1:0]     bucket;
   } medt_item_type;

   typedef struct packed {
      logic [EDGE_IDX_W-1:0]   edge_index;
      logic [MIDPOINT_W-1:0]   midpoint_vertex;
      logic                    is_new;
      logic [VERT_W-1:0]       low_vertex;
      logic [VERT_W-1:0]       high_vertex;
      logic [MASK_W-1:0]       face_mask;
      logic                    table_full;
      logic [COUNT_W-1:0]      edge_count;
   } medt_result_type;

endpackage
`default_nettype wire

>>> design/medt_front.sv
// Front end: accept requests, order the endpoints and hash the pair.
`default_nettype none
module medt_front
   import medt_pkg::*;
#(
   parameter int BUCKET_BITS_MAX = BUCKET_BITS_MAX_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [1:0]          in_kind,
   input  wire logic [VERT_W-1:0]   in_vert_a,
   input  wire logic [VERT_W-1:0]   in_vert_b,
   input  wire logic                in_front,
   input  wire logic [EDGE_IDX_W-1:0] in_sel,
   input  wire logic [BBITS_W-1:0]  bucket_bits,
   input  wire logic                hold,
   output logic                     q_valid,
   input  wire logic                q_ready,
   output medt_item_type            q_item
);

   logic          s1_valid_ff, s1_valid_in;
   medt_item_type s1_ff, s1_in;
   logic          s2_valid_ff, s2_valid_in;
   medt_item_type s2_ff;
   logic [31:0]   plo_ff, phi_ff;
   logic          s1_adv, s2_adv;
   logic [4:0]    eff_bits;
   logic [BUCKET_W-1:0] bmask;
   logic [31:0]   hash;

   assign s2_adv   = !s2_valid_ff || q_ready;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv && !hold;

   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_adv) begin
         s1_valid_in   = in_valid && in_ready;
         s1_in.kind    = req_kind_type'(in_kind);
         s1_in.lo      = (in_vert_a < in_vert_b) ? in_vert_a : in_vert_b;
         s1_in.hi      = (in_vert_a < in_vert_b) ? in_vert_b : in_vert_a;
         s1_in.front   = in_front;
         s1_in.sel     = in_sel;
         s1_in.bucket  = '0;
      end
      s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_ff <= s1_in;
      if (s2_adv) begin
         s2_ff  <= s1_ff;
         plo_ff <= 32'(32'(s1_ff.lo) * HASH_MUL_LOW);
         phi_ff <= 32'(32'(s1_ff.hi) * HASH_MUL_HIGH);
      end
   end

   always_comb begin
      if (5'(bucket_bits) < 5'(BUCKET_MIN)) begin
         eff_bits = 5'(BUCKET_MIN);
      end else if (5'(bucket_bits) > 5'(BUCKET_BITS_MAX)) begin
         eff_bits = 5'(BUCKET_BITS_MAX);
      end else begin
         eff_bits = 5'(bucket_bits);
      end
      for (int i = 0; i < BUCKET_W; i++) begin
         bmask[i] = (5'(i) < eff_bits);
      end
      hash          = plo_ff ^ phi_ff;
      q_item        = s2_ff;
      q_item.bucket = hash[BUCKET_W-1:0] & bmask;
   end

   assign q_valid = s2_valid_ff;

endmodule
`default_nettype wire

>>> design/medt_fifo.sv
// Two-entry queue between the front end and the table engine.
`default_nettype none
module medt_fifo
   import medt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire medt_item_type push_item,
   output logic               not_full,
   input  wire logic          pop,
   output medt_item_type      pop_item,
   output logic               not_empty
);

   medt_item_type slot_ff [2];
   logic          wptr_ff, rptr_ff;
   logic [1:0]    fill_ff;
   logic          do_push, do_pop;

   assign not_full  = (fill_ff != 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_item  = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (do_push) wptr_ff <= !wptr_ff;
         if (do_pop) rptr_ff <= !rptr_ff;
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
      if (do_push) slot_ff[wptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

>>> design/medt_back.sv
// Table engine: bucket heads, edge store, chain walk and result register.
`default_nettype none
module medt_back
   import medt_pkg::*;
#(
   parameter int EDGE_CAPACITY   = EDGE_CAPACITY_DEF,
   parameter int BUCKET_BITS_MAX = BUCKET_BITS_MAX_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire medt_item_type     q_item,
   output logic                   q_pop,
   input  wire logic [BASE_W-1:0] base_vertex,
   output logic                   sweeping,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output medt_result_type        out_result
);

   localparam int AW    = $clog2(EDGE_CAPACITY);
   localparam int CW    = $clog2(EDGE_CAPACITY + 1);
   localparam int HEADS = 1 << BUCKET_BITS_MAX;
   localparam logic [CW-1:0] NIL = CW'(EDGE_CAPACITY);

   logic [CW-1:0]     head_mem [HEADS];
   logic [VERT_W-1:0] lo_mem   [EDGE_CAPACITY];
   logic [VERT_W-1:0] hi_mem   [EDGE_CAPACITY];
   logic [MASK_W-1:0] mask_mem [EDGE_CAPACITY];
   logic [CW-1:0]     next_mem [EDGE_CAPACITY];

   medt_state_type state_ff, state_in;
   medt_item_type  item_ff, item_in;
   medt_result_type res_ff, res_in, out_ff;
   logic           out_valid_ff, out_valid_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  cur_ff, cur_in;
   logic [CW-1:0]  headv_ff, headv_in;
   logic [BUCKET_BITS_MAX-1:0] sweep_ff, sweep_in;

   logic [BUCKET_BITS_MAX-1:0] head_raddr, head_waddr;
   logic [CW-1:0]     head_wdata, head_rd_ff;
   logic              head_we;
   logic [AW-1:0]     edge_raddr, edge_waddr;
   logic              edge_we;
   logic [VERT_W-1:0] lo_wdata, hi_wdata, lo_rd_ff, hi_rd_ff;
   logic [MASK_W-1:0] mask_wdata, mask_rd_ff, facebit;
   logic [CW-1:0]     next_wdata, next_rd_ff;

   function automatic medt_result_type out_in_sel(input logic v, input logic rdy,
                                                  input medt_state_type st,
                                                  input medt_result_type r,
                                                  input medt_result_type o);
      if (st == ST_OUT && (!v || rdy)) begin
         return r;
      end
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_waddr] <= head_wdata;
      head_rd_ff <= head_mem[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         lo_mem[edge_waddr]   <= lo_wdata;
         hi_mem[edge_waddr]   <= hi_wdata;
         mask_mem[edge_waddr] <= mask_wdata;
         next_mem[edge_waddr] <= next_wdata;
      end
      lo_rd_ff   <= lo_mem[edge_raddr];
      hi_rd_ff   <= hi_mem[edge_raddr];
      mask_rd_ff <= mask_mem[edge_raddr];
      next_rd_ff <= next_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         item_ff.kind <= REQ_NONE;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         item_ff.kind <= item_in.kind;
      end
      item_ff.lo     <= item_in.lo;
      item_ff.hi     <= item_in.hi;
      item_ff.front  <= item_in.front;
      item_ff.sel    <= item_in.sel;
      item_ff.bucket <= item_in.bucket;
      res_ff         <= res_in;
      out_ff         <= out_in_sel(out_valid_ff, out_ready, state_ff, res_ff, out_ff);
      cur_ff         <= cur_in;
      headv_ff       <= headv_in;
   end

   assign facebit = item_ff.front ? FACE_FRONT : FACE_BACK;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      headv_in     = headv_ff;
      sweep_in     = sweep_ff;
      out_valid_in = out_valid_ff && !out_ready;
      q_pop        = 1'b0;
      head_raddr   = q_item.bucket[BUCKET_BITS_MAX-1:0];
      head_waddr   = sweep_ff;
      head_wdata   = NIL;
      head_we      = 1'b0;
      edge_raddr   = q_item.sel[AW-1:0];
      edge_waddr   = count_ff[AW-1:0];
      edge_we      = 1'b0;
      lo_wdata     = item_ff.lo;
      hi_wdata     = item_ff.hi;
      mask_wdata   = facebit;
      next_wdata   = headv_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            head_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (&sweep_ff) begin
               state_in = (item_ff.kind == REQ_CLEAR) ? ST_OUT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               res_in  = '0;
               res_in.edge_count = COUNT_W'(count_ff);
               case (q_item.kind)
                  REQ_INSERT: state_in = ST_HEAD;
                  REQ_READ:   state_in = ST_READ;
                  REQ_CLEAR: begin
                     count_in          = '0;
                     sweep_in          = '0;
                     res_in.edge_count = '0;
                     state_in          = ST_CLEAR;
                  end
                  default:    state_in = ST_OUT;
               endcase
            end
         end
         ST_HEAD: begin
            headv_in   = head_rd_ff;
            cur_in     = head_rd_ff;
            edge_raddr = head_rd_ff[AW-1:0];
            state_in   = (head_rd_ff < count_ff) ? ST_NODE : ST_MISS;
         end
         ST_NODE: begin
            if (lo_rd_ff == item_ff.lo && hi_rd_ff == item_ff.hi) begin
               edge_we                = 1'b1;
               edge_waddr             = cur_ff[AW-1:0];
               mask_wdata             = mask_rd_ff | facebit;
               next_wdata             = next_rd_ff;
               res_in.edge_index      = EDGE_IDX_W'(cur_ff);
               res_in.midpoint_vertex = MIDPOINT_W'(base_vertex) + MIDPOINT_W'(cur_ff);
               res_in.low_vertex      = item_ff.lo;
               res_in.high_vertex     = item_ff.hi;
               res_in.face_mask       = mask_rd_ff | facebit;
               state_in               = ST_OUT;
            end else if (next_rd_ff < count_ff) begin
               cur_in     = next_rd_ff;
               edge_raddr = next_rd_ff[AW-1:0];
            end else begin
               state_in = ST_MISS;
            end
         end
         ST_MISS: begin
            res_in.low_vertex  = item_ff.lo;
            res_in.high_vertex = item_ff.hi;
            if (count_ff >= NIL) begin
               res_in.table_full = 1'b1;
            end else begin
               edge_we                = 1'b1;
               head_we                = 1'b1;
               head_waddr             = item_ff.bucket[BUCKET_BITS_MAX-1:0];
               head_wdata             = count_ff;
               count_in               = count_ff + 1'b1;
               res_in.edge_index      = EDGE_IDX_W'(count_ff);
               res_in.midpoint_vertex = MIDPOINT_W'(base_vertex) + MIDPOINT_W'(count_ff);
               res_in.is_new          = 1'b1;
               res_in.face_mask       = facebit;
               res_in.edge_count      = COUNT_W'(count_ff + 1'b1);
            end
            state_in = ST_OUT;
         end
         ST_READ: begin
            res_in.edge_index = item_ff.sel;
            if (32'(item_ff.sel) < 32'(count_ff)) begin
               res_in.midpoint_vertex = MIDPOINT_W'(base_vertex) + MIDPOINT_W'(item_ff.sel);
               res_in.low_vertex      = lo_rd_ff;
               res_in.high_vertex     = hi_rd_ff;
               res_in.face_mask       = mask_rd_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign sweeping   = (state_ff == ST_CLEAR);
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule
`default_nettype wire

>>> design/mesh_edge_dedup_table_unit.sv
// Mesh edge dedup table: top level with configuration registers.
//
// Requests enter on req_ (tuser = request kind, tdata = endpoints, facing
// flag and read index); one result per request leaves on rsp_. Inserts
// order the endpoint pair, hash it and walk the bucket chain; reads fetch
// a stored record; clears empty every bucket and zero the edge count.
// Configuration writes on csr_ are taken every cycle: index 0 sets the
// first midpoint vertex number, index 1 sets log2 of the bucket count.
// The front end registers the ordered pair, then the two hash products, and
// forms the hash combinationally; the engine then reads the bucket head and
// visits chain entries, each a read of the edge store, before loading the
// result register, and takes no new item until that result is loaded. A clear
// sweeps all 2**BUCKET_BITS_MAX bucket heads, one head per cycle.
// After reset the same sweep runs and req_tready stays low until it ends.
// A stalled receiver holds the result in the output register while the
// engine finishes the next item; the two-entry queue keeps the front end
// accepting until it fills.
`default_nettype none
module mesh_edge_dedup_table_unit
   import medt_pkg::*;
#(
   parameter int EDGE_CAPACITY   = EDGE_CAPACITY_DEF,
   parameter int BUCKET_BITS_MAX = BUCKET_BITS_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [11:0] vert_a, [23:12] vert_b, [24] front_facing, [37:25] edge_select
   input  wire logic [39:0] req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [12:0] edge_index, [26:13] midpoint_vertex, [38:27] low_vertex,
   // [50:39] high_vertex, [52:51] face_mask, [66:53] edge_count
   output logic [71:0]      rsp_tdata,
   // [0] is_new, [1] table_full
   output logic [1:0]       rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [11:0] csr_data
);

   logic [BASE_W-1:0]  base_vertex_ff;
   logic [BBITS_W-1:0] bucket_bits_ff;
   logic               q_in_valid, q_in_ready, q_out_valid, q_pop, sweeping;
   medt_item_type      q_in_item, q_out_item;
   medt_result_type    res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_vertex_ff <= '0;
         bucket_bits_ff <= BBITS_W'(BUCKET_MIN);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_VERTEX: base_vertex_ff <= csr_data;
            CSR_BUCKET_BITS: bucket_bits_ff <= csr_data[BBITS_W-1:0];
            default: ;
         endcase
      end
   end

   medt_front #(
      .BUCKET_BITS_MAX (BUCKET_BITS_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_kind     (req_tuser),
      .in_vert_a   (req_tdata[11:0]),
      .in_vert_b   (req_tdata[23:12]),
      .in_front    (req_tdata[24]),
      .in_sel      (req_tdata[37:25]),
      .bucket_bits (bucket_bits_ff),
      .hold        (sweeping),
      .q_valid     (q_in_valid),
      .q_ready     (q_in_ready),
      .q_item      (q_in_item)
   );

   medt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_in_valid),
      .push_item (q_in_item),
      .not_full  (q_in_ready),
      .pop       (q_pop),
      .pop_item  (q_out_item),
      .not_empty (q_out_valid)
   );

   medt_back #(
      .EDGE_CAPACITY   (EDGE_CAPACITY),
      .BUCKET_BITS_MAX (BUCKET_BITS_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_out_valid),
      .q_item      (q_out_item),
      .q_pop       (q_pop),
      .base_vertex (base_vertex_ff),
      .sweeping    (sweeping),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (res)
   );

   assign rsp_tdata = {5'd0, res.edge_count, res.face_mask, res.high_vertex,
                       res.low_vertex, res.midpoint_vertex, res.edge_index};
   assign rsp_tuser = {res.table_full, res.is_new};

endmodule
`default_nettype wire

>>> bench/mesh_edge_dedup_table_unit_tb.sv
// Testbench for the mesh edge dedup table: random and directed requests checked by a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module mesh_edge_dedup_table_unit_tb;
   import medt_pkg::*;

   localparam int CAP = EDGE_CAPACITY_DEF;
   localparam int NBKT = 1 << BUCKET_BITS_MAX_DEF;
   localparam int NIL = CAP;
   localparam int CYCLE_LIMIT = 2000000;

   class edge_table_scoreboard;
      int unsigned heads[NBKT];
      bit [11:0] low_mem[CAP];
      bit [11:0] high_mem[CAP];
      bit [1:0] mask_mem[CAP];
      int unsigned next_mem[CAP];
      int unsigned count;
      bit [11:0] base;
      bit [3:0] bbits;
      medt_result_type pending[$];
      int errors;

      function void clear_table();
         foreach (heads[i]) heads[i] = NIL;
         count = 0;
      endfunction

      function void init();
         base = 0;
         bbits = 4;
         errors = 0;
         clear_table();
      endfunction

      function void note_request(req_kind_type kind, bit [11:0] va, bit [11:0] vb,
                                 bit front, bit [12:0] sel);
         medt_result_type r;
         bit [11:0] lo, hi;
         bit [31:0] h;
         bit [1:0] fb;
         int unsigned nb, bkt, e, steps;
         r = '0;
         case (kind)
            REQ_INSERT: begin
               lo = va < vb ? va : vb;
               hi = va < vb ? vb : va;
               fb = front ? FACE_FRONT : FACE_BACK;
               h = (32'(lo) * HASH_MUL_LOW) ^ (32'(hi) * HASH_MUL_HIGH);
               nb = bbits < BUCKET_MIN ? BUCKET_MIN :
                    (bbits > BUCKET_BITS_MAX_DEF ? BUCKET_BITS_MAX_DEF : bbits);
               bkt = h & ((32'd1 << nb) - 1);
               e = heads[bkt];
               steps = 0;
               while (e < count && steps < CAP) begin
                  if (low_mem[e] == lo && high_mem[e] == hi) break;
                  e = next_mem[e];
                  steps++;
               end
               r.low_vertex = lo;
               r.high_vertex = hi;
               if (e < count && steps < CAP) begin
                  mask_mem[e] |= fb;
                  r.edge_index = 13'(e);
                  r.midpoint_vertex = 14'(base + e);
                  r.face_mask = mask_mem[e];
               end else if (count >= CAP) begin
                  r.table_full = 1;
               end else begin
                  e = count;
                  low_mem[e] = lo;
                  high_mem[e] = hi;
                  mask_mem[e] = fb;
                  next_mem[e] = heads[bkt];
                  heads[bkt] = e;
                  count++;
                  r.edge_index = 13'(e);
                  r.midpoint_vertex = 14'(base + e);
                  r.is_new = 1;
                  r.face_mask = fb;
               end
            end
            REQ_READ: begin
               r.edge_index = sel;
               if (sel < count) begin
                  r.midpoint_vertex = 14'(base + sel);
                  r.low_vertex = low_mem[sel];
                  r.high_vertex = high_mem[sel];
                  r.face_mask = mask_mem[sel];
               end
            end
            REQ_CLEAR: clear_table();
            default: ;
         endcase
         if (kind != REQ_CLEAR) r.edge_count = 14'(count);
         pending.push_back(r);
      endfunction

      function void check_result(medt_result_type got);
         medt_result_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.edge_index != exp.edge_index ||
             got.midpoint_vertex != exp.midpoint_vertex ||
             got.is_new != exp.is_new || got.low_vertex != exp.low_vertex ||
             got.high_vertex != exp.high_vertex || got.face_mask != exp.face_mask ||
             got.table_full != exp.table_full || got.edge_count != exp.edge_count) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, exp, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_index = 0;
   logic [11:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   bit long_hold = 0;
   bit hold_done = 0;
   int unsigned cycle_count = 0;
   edge_table_scoreboard board = new();

   mesh_edge_dedup_table_unit dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) begin
         medt_result_type got;
         got.edge_index = rsp_tdata[12:0];
         got.midpoint_vertex = rsp_tdata[26:13];
         got.low_vertex = rsp_tdata[38:27];
         got.high_vertex = rsp_tdata[50:39];
         got.face_mask = rsp_tdata[52:51];
         got.edge_count = rsp_tdata[66:53];
         got.is_new = rsp_tuser[0];
         got.table_full = rsp_tuser[1];
         board.check_result(got);
      end

   always @(negedge clock)
      if (hold_cycles > 0) begin
         rsp_tready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else if (long_hold && !hold_done) begin
         rsp_tready <= 0;
         hold_cycles <= 299;
         hold_done <= 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end

   task automatic write_csr(bit idx, bit [11:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_BASE_VERTEX) board.base = val;
      else board.bbits = val[3:0];
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic send_request(req_kind_type kind, bit [11:0] va, bit [11:0] vb,
                               bit front, bit [12:0] sel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {2'b0, sel, front, vb, va};
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, va, vb, front, sel);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_burst(int n, int vrange);
      req_kind_type kind;
      int unsigned roll;
      bit [11:0] va, vb;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         va = 12'($urandom_range(vrange));
         vb = 12'($urandom_range(vrange));
         if (roll < 2) va = 12'($urandom);
         if (roll < 70) kind = REQ_INSERT;
         else if (roll < 92) kind = REQ_READ;
         else if (roll < 97) kind = REQ_NONE;
         else kind = REQ_CLEAR;
         send_request(kind, va, vb, 1'($urandom_range(1)),
                      13'(($urandom_range(99) < 80 && board.count > 0) ?
                          $urandom_range(board.count - 1) : $urandom));
      end
   endtask

   initial begin
      board.init();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_request(REQ_INSERT, 12'd0, 12'd0, 1, 0);
      send_request(REQ_INSERT, 12'hFFF, 12'd0, 0, 0);
      send_request(REQ_INSERT, 12'd0, 12'hFFF, 1, 0);
      send_request(REQ_INSERT, 12'hFFF, 12'hFFF, 0, 0);
      send_request(REQ_INSERT, 12'd5, 12'd3, 0, 0);
      send_request(REQ_INSERT, 12'd3, 12'd5, 0, 0);
      send_request(REQ_INSERT, 12'hAAA, 12'h555, 1, 13'h1FFF);
      send_request(REQ_READ, 0, 0, 0, 13'd1);
      send_request(REQ_READ, 0, 0, 0, 13'd2);
      send_request(REQ_READ, 0, 0, 0, 13'h1FFF);
      send_request(REQ_NONE, 12'hFFF, 12'hFFF, 1, 13'h1FFF);
      send_request(REQ_CLEAR, 0, 0, 0, 0);
      send_request(REQ_READ, 0, 0, 0, 13'd0);
      send_request(REQ_INSERT, 12'd7, 12'd9, 1, 0);
      drain();

      write_csr(CSR_BASE_VERTEX, 12'hFFF);
      write_csr(CSR_BUCKET_BITS, 12'd0);
      send_idle_pct = 21;
      recv_idle_pct = 79;
      random_burst(250, 63);
      drain();

      write_csr(CSR_BASE_VERTEX, 12'd0);
      write_csr(CSR_BUCKET_BITS, 12'd15);
      send_idle_pct = 79;
      recv_idle_pct = 21;
      random_burst(250, 4095);
      drain();

      write_csr(CSR_BASE_VERTEX, 12'd1234);
      write_csr(CSR_BUCKET_BITS, 12'd12);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(negedge clock);
      long_hold = 1;
      random_burst(300, 255);
      drain();

      write_csr(CSR_BUCKET_BITS, 12'd6);
      random_burst(300, 31);
      drain();

      if (board.errors == 0 && board.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

>>> mesh_edge_dedup_table_unit.f
design/medt_pkg.sv
design/medt_front.sv
design/medt_fifo.sv
design/medt_back.sv
design/mesh_edge_dedup_table_unit.sv
bench/mesh_edge_dedup_table_unit_tb.sv
